>>> design/lrc_pkg.sv
// Shared types, constants and constant tables for the lidar return converter.
// No dependencies; all other design files but lrc_checker refer to it by scoped names.
package lrc_pkg;

    localparam int LASERS            = 16;
    localparam int BLOCKS_PER_PACKET = 12;
    localparam int TRIG_FRAC_BITS    = 16;

    localparam int LASER_W = $clog2(LASERS);
    localparam int RET_W   = LASER_W + 1;
    localparam int BLK_W   = $clog2(BLOCKS_PER_PACKET);
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;

    localparam int AZ_FULL    = 36000;
    localparam int AZ_HALF    = 18000;
    localparam int AZ_QUARTER = 9000;
    localparam int AZ_OCTANT  = 4500;

    localparam int FRAME_MIN_RESET = 500;
    localparam int FRAME_LIM_RESET = 200;
    localparam int FRAME_CNT_W     = 10;

    localparam int QB = 30;
    localparam longint unsigned Q_ONE  = 64'd1 << QB;
    localparam longint unsigned PI_Q30 = 64'd3373259426;
    // angle in Q30 radians = a*PI_STEP + (a*PI_REM + AZ_QUARTER) / AZ_HALF
    localparam longint unsigned PI_STEP = PI_Q30 / AZ_HALF;
    localparam longint unsigned PI_REM  = PI_Q30 % AZ_HALF;
    localparam longint unsigned RECIP_HALF = (64'd1 << 32) / AZ_HALF;
    localparam longint unsigned TRIG_HALF  = 64'd1 << (QB - TRIG_FRAC_BITS - 1);

    localparam int SIN_STEPS = 5;
    localparam int COS_STEPS = 6;
    localparam logic [7:0] SIN_DIV [SIN_STEPS] = '{8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [7:0] COS_DIV [COS_STEPS] =
        '{8'd132, 8'd90, 8'd56, 8'd30, 8'd12, 8'd2};
    localparam logic [31:0] SIN_RECIP [SIN_STEPS] = '{
        32'((64'd1 << 32) / 110), 32'((64'd1 << 32) / 72), 32'((64'd1 << 32) / 42),
        32'((64'd1 << 32) / 20), 32'((64'd1 << 32) / 6)};
    localparam logic [31:0] COS_RECIP [COS_STEPS] = '{
        32'((64'd1 << 32) / 132), 32'((64'd1 << 32) / 90), 32'((64'd1 << 32) / 56),
        32'((64'd1 << 32) / 30), 32'((64'd1 << 32) / 12), 32'((64'd1 << 32) / 2)};

    localparam int ELEV [LASERS] = '{
        -1500, 100, -1300, 300, -1100, 500, -900, 700,
        -700, 900, -500, 1100, -300, 1300, -100, 1500};

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_MIN_POINTS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_START_AZ_LIMIT = 1'd1;

    typedef logic signed [TRIG_W-1:0] t_trig_tab [LASERS];

    typedef struct packed {
        logic [15:0]        az;
        logic [LASER_W-1:0] laser;
        logic [15:0]        rng;
        logic [7:0]         refl;
        logic               new_frame;
        logic               last;
    } t_job;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic {F_IDLE, F_REPLAY} t_front_state;

    typedef enum logic [3:0] {
        B_IDLE, B_ANG0, B_ANG1, B_ANG2, B_ANGF, B_SQ, B_MUL, B_REC, B_FIX,
        B_FIN, B_MAP, B_PROD0, B_PROD1, B_OUT
    } t_back_state;

    // first-octant sin and cos, evaluated at elaboration only: {sin, cos}
    function automatic logic [2*TRIG_FRAC_BITS+1:0] oct_trig_c(input int unsigned a);
        longint unsigned x, x2, t, s, c;
        x  = (longint'(a) * PI_Q30 + AZ_QUARTER) / AZ_HALF;
        x2 = (x * x) >> QB;
        t  = Q_ONE;
        for (int i = 0; i < SIN_STEPS; i++) begin
            t = Q_ONE - ((x2 * t) >> QB) / SIN_DIV[i];
        end
        s = (((x * t) >> QB) + TRIG_HALF) >> (QB - TRIG_FRAC_BITS);
        t = Q_ONE;
        for (int i = 0; i < COS_STEPS; i++) begin
            t = Q_ONE - ((x2 * t) >> QB) / COS_DIV[i];
        end
        c = (t + TRIG_HALF) >> (QB - TRIG_FRAC_BITS);
        return {s[TRIG_FRAC_BITS:0], c[TRIG_FRAC_BITS:0]};
    endfunction

    function automatic t_trig_tab el_trig_tab(input bit want_sin);
        t_trig_tab tab;
        int a, q, r;
        logic [2*TRIG_FRAC_BITS+1:0] sc;
        logic signed [TRIG_W-1:0] sp, cp, sn, cs, s, c;
        for (int l = 0; l < LASERS; l++) begin
            a = (ELEV[l] < 0) ? ELEV[l] + AZ_FULL : ELEV[l];
            q = a / AZ_QUARTER;
            r = a % AZ_QUARTER;
            if (r > AZ_OCTANT) begin
                sc = oct_trig_c(AZ_QUARTER - r);
            end else begin
                sc = oct_trig_c(r);
            end
            sp = $signed({1'b0, sc[2*TRIG_FRAC_BITS+1:TRIG_FRAC_BITS+1]});
            cp = $signed({1'b0, sc[TRIG_FRAC_BITS:0]});
            sn = (r > AZ_OCTANT) ? cp : sp;
            cs = (r > AZ_OCTANT) ? sp : cp;
            case (q)
                0:       begin s = sn;  c = cs;  end
                1:       begin s = cs;  c = -sn; end
                2:       begin s = -sn; c = -cs; end
                default: begin s = -cs; c = sn;  end
            endcase
            tab[l] = want_sin ? s : c;
        end
        return tab;
    endfunction

    localparam t_trig_tab EL_SIN = el_trig_tab(1'b1);
    localparam t_trig_tab EL_COS = el_trig_tab(1'b0);

endpackage

>>> design/lrc_front.sv
// Front end: accepts returns, tracks block/return counters and frames,
// buffers the second half of each block but a packet's last and issues point jobs. Uses lrc_pkg.
module lrc_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_first_in_packet,
    input  logic [15:0]                    i_azimuth,
    input  logic [15:0]                    i_distance,
    input  logic [7:0]                     i_reflectivity,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  lrc_pkg::t_q_stat               i_q_stat,
    output logic                           o_push,
    output lrc_pkg::t_job                  o_job
);

    lrc_pkg::t_front_state r_state, n_state;

    logic [lrc_pkg::FRAME_CNT_W-1:0] r_cfg_min;
    logic [15:0]                     r_cfg_lim;
    logic [15:0]                     r_prev_az, r_prev_mid, r_last_half;
    logic [lrc_pkg::BLK_W-1:0]       r_blk;
    logic [lrc_pkg::RET_W-1:0]       r_ret;
    logic [lrc_pkg::FRAME_CNT_W-1:0] r_frame_cnt;
    logic                            r_any_open;
    logic [lrc_pkg::RET_W-1:0]       r_rp_idx;
    logic [15:0]                     r_hold_dist;
    logic [7:0]                      r_hold_refl;
    logic                            r_mid_nf, r_fin_nf;
    logic [23:0]                     r_buf [lrc_pkg::LASERS];

    logic                            accept;
    logic [15:0]                     az_c;
    logic [lrc_pkg::BLK_W-1:0]       blk_c, blk_nx;
    logic [lrc_pkg::RET_W-1:0]       ret_c, ret_nx;
    logic [16:0]                     mid_sum;
    logic [15:0]                     mid_half, mid_c;
    logic signed [17:0]              ext_raw, ext_fix;
    logic [15:0]                     ext_c;
    logic                            last_blk;
    logic                            nf_b0;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != lrc_pkg::F_IDLE) || i_q_stat.full;
    assign accept      = i_valid && !o_stall;

    always_comb begin
        az_c  = (i_azimuth >= 16'(lrc_pkg::AZ_FULL)) ?
                16'(i_azimuth - 16'(lrc_pkg::AZ_FULL)) : i_azimuth;
        blk_c = i_first_in_packet ? '0 : r_blk;
        ret_c = i_first_in_packet ? '0 : r_ret;
        last_blk = (blk_c == lrc_pkg::BLK_W'(lrc_pkg::BLOCKS_PER_PACKET - 1));

        // modular midpoint of the previous block azimuth and this one
        mid_sum  = 17'(r_prev_az) + 17'(az_c) +
                   ((az_c < r_prev_az) ? 17'(lrc_pkg::AZ_FULL) : 17'd0);
        mid_half = mid_sum[16:1];
        mid_c    = (mid_half >= 16'(lrc_pkg::AZ_FULL)) ?
                   16'(mid_half - 16'(lrc_pkg::AZ_FULL)) : mid_half;

        // extrapolate the last half block, wrapped into one turn
        ext_raw = $signed({1'b0, r_prev_az, 1'b0}) - $signed({2'b00, r_prev_mid});
        if (ext_raw < 0) begin
            ext_fix = ext_raw + 18'sd36000;
        end else if (ext_raw >= 18'sd36000) begin
            ext_fix = ext_raw - 18'sd36000;
        end else begin
            ext_fix = ext_raw;
        end
        ext_c = ext_fix[15:0];

        nf_b0 = !r_any_open ||
                ((r_frame_cnt > r_cfg_min) && (az_c < r_cfg_lim));

        ret_nx = ret_c + 1'b1;
        blk_nx = blk_c;
        if (ret_nx == '0) begin
            blk_nx = (blk_c == lrc_pkg::BLK_W'(lrc_pkg::BLOCKS_PER_PACKET - 1)) ?
                     '0 : blk_c + 1'b1;
        end
    end

    // job issue and next state
    always_comb begin
        n_state = r_state;
        o_push  = 1'b0;
        o_job   = '{az: r_prev_az, laser: ret_c[lrc_pkg::LASER_W-1:0],
                    rng: i_distance, refl: i_reflectivity, new_frame: 1'b0, last: 1'b1};
        case (r_state)
            lrc_pkg::F_IDLE: begin
                if (accept) begin
                    if (ret_c == '0) begin
                        if (blk_c == '0) begin
                            o_push          = 1'b1;
                            o_job.az        = az_c;
                            o_job.new_frame = nf_b0;
                        end else begin
                            n_state = lrc_pkg::F_REPLAY;
                        end
                    end else if (ret_c < lrc_pkg::RET_W'(lrc_pkg::LASERS)) begin
                        o_push = 1'b1;
                    end else if (last_blk) begin
                        o_push = 1'b1;
                        if (ret_c == lrc_pkg::RET_W'(lrc_pkg::LASERS)) begin
                            o_job.az        = ext_c;
                            o_job.new_frame = ext_c < r_prev_az;
                        end else begin
                            o_job.az = r_last_half;
                        end
                    end
                end
            end
            lrc_pkg::F_REPLAY: begin
                if (!i_q_stat.full) begin
                    o_push = 1'b1;
                    if (r_rp_idx == lrc_pkg::RET_W'(lrc_pkg::LASERS)) begin
                        o_job = '{az: r_prev_az, laser: '0, rng: r_hold_dist,
                                  refl: r_hold_refl, new_frame: r_fin_nf, last: 1'b1};
                        n_state = lrc_pkg::F_IDLE;
                    end else begin
                        o_job = '{az: r_prev_mid,
                                  laser: r_rp_idx[lrc_pkg::LASER_W-1:0],
                                  rng: r_buf[r_rp_idx[lrc_pkg::LASER_W-1:0]][15:0],
                                  refl: r_buf[r_rp_idx[lrc_pkg::LASER_W-1:0]][23:16],
                                  new_frame: (r_rp_idx == '0) && r_mid_nf, last: 1'b0};
                    end
                end
            end
            default: n_state = lrc_pkg::F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrc_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_min   <= lrc_pkg::FRAME_CNT_W'(lrc_pkg::FRAME_MIN_RESET);
            r_cfg_lim   <= 16'(lrc_pkg::FRAME_LIM_RESET);
            r_prev_az   <= '0;
            r_prev_mid  <= '0;
            r_last_half <= '0;
            r_blk       <= '0;
            r_ret       <= '0;
            r_frame_cnt <= '0;
            r_any_open  <= 1'b0;
            r_rp_idx    <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    lrc_pkg::CFG_FRAME_MIN_POINTS:
                        r_cfg_min <= i_cfg_data[lrc_pkg::FRAME_CNT_W-1:0];
                    lrc_pkg::CFG_FRAME_START_AZ_LIMIT:
                        r_cfg_lim <= i_cfg_data;
                    default: ;
                endcase
            end
            if (accept) begin
                r_ret <= ret_nx;
                r_blk <= blk_nx;
                if (ret_c == '0) begin
                    r_prev_az <= az_c;
                    if (blk_c != '0) begin
                        r_prev_mid <= mid_c;
                    end
                end
                if (last_blk && ret_c == lrc_pkg::RET_W'(lrc_pkg::LASERS)) begin
                    r_last_half <= ext_c;
                end
                r_rp_idx <= '0;
            end else if (r_state == lrc_pkg::F_REPLAY && o_push) begin
                r_rp_idx <= r_rp_idx + 1'b1;
            end
            if (o_push) begin
                if (o_job.new_frame) begin
                    r_frame_cnt <= lrc_pkg::FRAME_CNT_W'(1);
                    r_any_open  <= 1'b1;
                end else if (r_frame_cnt != '1) begin
                    r_frame_cnt <= r_frame_cnt + 1'b1;
                end
            end
        end
    end

    // payload: held final return and the half-block buffer
    always_ff @(posedge i_clk) begin
        if (accept && ret_c == '0 && blk_c != '0) begin
            r_hold_dist <= i_distance;
            r_hold_refl <= i_reflectivity;
            r_mid_nf    <= mid_c < r_prev_az;
            r_fin_nf    <= az_c < mid_c;
        end
        if (accept && ret_c[lrc_pkg::LASER_W] && !last_blk) begin
            r_buf[ret_c[lrc_pkg::LASER_W-1:0]] <= {i_reflectivity, i_distance};
        end
    end

endmodule

>>> design/lrc_queue.sv
// Short job queue between the front end and the point unit.
// Depends on lrc_pkg for the job type and depth.
module lrc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  lrc_pkg::t_job    i_job,
    input  logic             i_pop,
    output lrc_pkg::t_job    o_job,
    output lrc_pkg::t_q_stat o_stat
);

    lrc_pkg::t_job                r_mem [lrc_pkg::QUEUE_DEPTH];
    logic [lrc_pkg::QPTR_W-1:0]   r_wr, r_rd;
    logic [lrc_pkg::QPTR_W:0]     r_cnt;

    assign o_job        = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == (lrc_pkg::QPTR_W+1)'(lrc_pkg::QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

>>> design/lrc_back.sv
// Point unit: sin/cos of the azimuth by a two-lane Horner sequencer, then
// the cartesian products and the output register. Depends on lrc_pkg.
module lrc_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  lrc_pkg::t_q_stat i_q_stat,
    input  lrc_pkg::t_job    i_job,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [17:0]      o_x_mm,
    output logic [17:0]      o_y_mm,
    output logic [17:0]      o_z_mm,
    output logic [7:0]       o_intensity,
    output logic [3:0]       o_laser_channel,
    output logic             o_new_frame,
    output logic             o_last
);

    localparam int F  = lrc_pkg::TRIG_FRAC_BITS;
    localparam int TW = lrc_pkg::TRIG_W;

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int sh);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        m = (m + (64'd1 << (sh - 1))) >> sh;
        return (v < 0) ? -$signed(m) : $signed(m);
    endfunction

    lrc_pkg::t_back_state r_state, n_state;

    lrc_pkg::t_job           r_job;
    logic [1:0]              r_quad;
    logic                    r_swap;
    logic [12:0]             r_arg;
    logic [29:0]             r_base, r_x, r_x2, r_ns, r_nc, r_qs, r_qc;
    logic [24:0]             r_num;
    logic [10:0]             r_qe;
    logic [30:0]             r_ts, r_tc;
    logic [2:0]              r_step;
    logic [F:0]              r_sn, r_cs;
    logic signed [TW-1:0]    r_sa, r_ca;
    logic [25:0]             r_r8;
    logic signed [17:0]      r_z, r_xo, r_yo;
    logic                    r_out_valid;

    logic [13:0]             rem_c;
    logic [1:0]              quad_c;
    logic [63:0]             p_a, p_b;
    logic [24:0]             fix_rem;
    logic [10:0]             fix_q;
    logic [7:0]              ds, dc;
    logic [31:0]             ms, mc;
    logic                    sin_on;
    logic [29:0]             rs, rc, qs_f, qc_f;
    logic [63:0]             fin_w, cos_w;
    logic signed [TW-1:0]    sn_s, cs_s;
    logic signed [TW-1:0]    el_s, el_c;
    logic [16:0]             d2;
    logic [63:0]             r8_w;
    logic signed [63:0]      z_w, x_w, y_w;
    logic                    out_free;

    assign out_free = !r_out_valid || !i_stall;
    assign o_pop    = (r_state == lrc_pkg::B_IDLE) && !i_q_stat.empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            lrc_pkg::B_IDLE:  if (!i_q_stat.empty) n_state = lrc_pkg::B_ANG0;
            lrc_pkg::B_ANG0:  n_state = lrc_pkg::B_ANG1;
            lrc_pkg::B_ANG1:  n_state = lrc_pkg::B_ANG2;
            lrc_pkg::B_ANG2:  n_state = lrc_pkg::B_ANGF;
            lrc_pkg::B_ANGF:  n_state = lrc_pkg::B_SQ;
            lrc_pkg::B_SQ:    n_state = lrc_pkg::B_MUL;
            lrc_pkg::B_MUL:   n_state = lrc_pkg::B_REC;
            lrc_pkg::B_REC:   n_state = lrc_pkg::B_FIX;
            lrc_pkg::B_FIX:   n_state = (r_step == 3'(lrc_pkg::COS_STEPS - 1)) ?
                                        lrc_pkg::B_FIN : lrc_pkg::B_MUL;
            lrc_pkg::B_FIN:   n_state = lrc_pkg::B_MAP;
            lrc_pkg::B_MAP:   n_state = lrc_pkg::B_PROD0;
            lrc_pkg::B_PROD0: n_state = lrc_pkg::B_PROD1;
            lrc_pkg::B_PROD1: n_state = lrc_pkg::B_OUT;
            lrc_pkg::B_OUT:   if (out_free) n_state = lrc_pkg::B_IDLE;
            default:          n_state = lrc_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lrc_pkg::B_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath arithmetic per sequencer step
    always_comb begin
        // quadrant and octant fold
        if (r_job.az >= 16'd27000) begin
            quad_c = 2'd3; rem_c = 14'(r_job.az - 16'd27000);
        end else if (r_job.az >= 16'(lrc_pkg::AZ_HALF)) begin
            quad_c = 2'd2; rem_c = 14'(r_job.az - 16'(lrc_pkg::AZ_HALF));
        end else if (r_job.az >= 16'(lrc_pkg::AZ_QUARTER)) begin
            quad_c = 2'd1; rem_c = 14'(r_job.az - 16'(lrc_pkg::AZ_QUARTER));
        end else begin
            quad_c = 2'd0; rem_c = r_job.az[13:0];
        end

        // angle correction: exact quotient by the azimuth half turn
        fix_rem = r_num - 25'(r_qe * 25'(lrc_pkg::AZ_HALF));
        fix_q   = (fix_rem >= 25'(lrc_pkg::AZ_HALF)) ? r_qe + 1'b1 : r_qe;

        // Horner divisors for this step; the sine lane starts one step late
        sin_on = (r_step != 3'd0);
        dc = lrc_pkg::COS_DIV[r_step];
        mc = lrc_pkg::COS_RECIP[r_step];
        ds = sin_on ? lrc_pkg::SIN_DIV[3'(r_step - 3'd1)] : 8'd1;
        ms = sin_on ? lrc_pkg::SIN_RECIP[3'(r_step - 3'd1)] : 32'd0;

        p_a = 64'(r_ns) * 64'(ms);
        p_b = 64'(r_nc) * 64'(mc);

        rs   = 30'(r_ns - 30'(r_qs * 30'(ds)));
        rc   = 30'(r_nc - 30'(r_qc * 30'(dc)));
        qs_f = (rs >= 30'(ds)) ? r_qs + 1'b1 : r_qs;
        qc_f = (rc >= 30'(dc)) ? r_qc + 1'b1 : r_qc;

        fin_w = ((((64'(r_x) * 64'(r_ts)) >> lrc_pkg::QB) + lrc_pkg::TRIG_HALF)
                 >> (lrc_pkg::QB - F));
        cos_w = ((64'(r_tc) + lrc_pkg::TRIG_HALF) >> (lrc_pkg::QB - F));

        sn_s = $signed({1'b0, (r_swap ? r_cs : r_sn)});
        cs_s = $signed({1'b0, (r_swap ? r_sn : r_cs)});

        el_s = lrc_pkg::EL_SIN[r_job.laser];
        el_c = lrc_pkg::EL_COS[r_job.laser];
        d2   = {r_job.rng, 1'b0};
        r8_w = ((64'(d2) * 64'(el_c)) + (64'd1 << (F - 9))) >> (F - 8);
        z_w  = rnd_shift(64'(signed'({1'b0, d2})) * 64'(el_s), F);
        x_w  = rnd_shift(64'(signed'({1'b0, r_r8})) * 64'(r_sa), F + 8);
        y_w  = rnd_shift(64'(signed'({1'b0, r_r8})) * 64'(r_ca), F + 8);
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            lrc_pkg::B_IDLE: begin
                if (!i_q_stat.empty) r_job <= i_job;
            end
            lrc_pkg::B_ANG0: begin
                r_quad <= quad_c;
                r_swap <= rem_c > 14'(lrc_pkg::AZ_OCTANT);
                r_arg  <= (rem_c > 14'(lrc_pkg::AZ_OCTANT)) ?
                          13'(14'(lrc_pkg::AZ_QUARTER) - rem_c) : rem_c[12:0];
            end
            lrc_pkg::B_ANG1: begin
                r_base <= 30'(64'(r_arg) * lrc_pkg::PI_STEP);
                r_num  <= 25'(64'(r_arg) * lrc_pkg::PI_REM + 64'(lrc_pkg::AZ_QUARTER));
            end
            lrc_pkg::B_ANG2: begin
                r_qe <= 11'((64'(r_num) * lrc_pkg::RECIP_HALF) >> 32);
            end
            lrc_pkg::B_ANGF: begin
                r_x <= r_base + 30'(fix_q);
            end
            lrc_pkg::B_SQ: begin
                r_x2   <= 30'((64'(r_x) * 64'(r_x)) >> lrc_pkg::QB);
                r_ts   <= 31'(lrc_pkg::Q_ONE);
                r_tc   <= 31'(lrc_pkg::Q_ONE);
                r_step <= '0;
            end
            lrc_pkg::B_MUL: begin
                r_ns <= 30'((64'(r_x2) * 64'(r_ts)) >> lrc_pkg::QB);
                r_nc <= 30'((64'(r_x2) * 64'(r_tc)) >> lrc_pkg::QB);
            end
            lrc_pkg::B_REC: begin
                r_qs <= p_a[61:32];
                r_qc <= p_b[61:32];
            end
            lrc_pkg::B_FIX: begin
                if (sin_on) r_ts <= 31'(lrc_pkg::Q_ONE) - 31'(qs_f);
                r_tc   <= 31'(lrc_pkg::Q_ONE) - 31'(qc_f);
                r_step <= r_step + 1'b1;
            end
            lrc_pkg::B_FIN: begin
                r_sn <= fin_w[F:0];
                r_cs <= cos_w[F:0];
            end
            lrc_pkg::B_MAP: begin
                case (r_quad)
                    2'd0:    begin r_sa <= sn_s;  r_ca <= cs_s;  end
                    2'd1:    begin r_sa <= cs_s;  r_ca <= -sn_s; end
                    2'd2:    begin r_sa <= -sn_s; r_ca <= -cs_s; end
                    default: begin r_sa <= -cs_s; r_ca <= sn_s;  end
                endcase
            end
            lrc_pkg::B_PROD0: begin
                r_r8 <= r8_w[25:0];
                r_z  <= z_w[17:0];
            end
            lrc_pkg::B_PROD1: begin
                r_xo <= x_w[17:0];
                r_yo <= y_w[17:0];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == lrc_pkg::B_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == lrc_pkg::B_OUT && out_free) begin
            o_x_mm          <= r_xo;
            o_y_mm          <= r_yo;
            o_z_mm          <= r_z;
            o_intensity     <= r_job.refl;
            o_laser_channel <= r_job.laser;
            o_new_frame     <= r_job.new_frame;
            o_last          <= r_job.last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

>>> design/lidar_return_to_cartesian_top.sv
// Top level of the lidar return to cartesian point converter.
// Instantiates lrc_front, lrc_queue and lrc_back; uses lrc_pkg.
//
//   channel   handshake                payload
//   input     i_valid / o_stall        i_first_in_packet i_azimuth i_distance i_reflectivity
//   output    o_valid / i_stall        o_x_mm o_y_mm o_z_mm o_intensity o_laser_channel
//                                      o_new_frame o_last
//   config    i_cfg_valid / o_cfg_ready i_cfg_index i_cfg_data
//
// Each point runs through the point unit in order: pop, angle setup (ANG0, ANG1, ANG2,
// ANGF, SQ), six two-lane Horner steps of MUL, REC and FIX, mapping and products
// (FIN, MAP, PROD0, PROD1), output load: the shared trig sequencer sets the rate. A
// return that yields no point is only buffered; any block's first return but a packet's
// first replays 16 buffered words, then itself, one per cycle while the queue is not full.
// Reset is synchronous, active low, and clears all control state.
// o_stall rises while the front replays or the four-word queue is full; i_stall
// holds the output word and, once the queue fills, backs up to the input.
module lidar_return_to_cartesian_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_first_in_packet,
    input  logic [15:0]                    i_azimuth,
    input  logic [15:0]                    i_distance,
    input  logic [7:0]                     i_reflectivity,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [lrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [lrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [17:0]                    o_x_mm,
    output logic [17:0]                    o_y_mm,
    output logic [17:0]                    o_z_mm,
    output logic [7:0]                     o_intensity,
    output logic [3:0]                     o_laser_channel,
    output logic                           o_new_frame,
    output logic                           o_last
);

    logic             push, pop;
    lrc_pkg::t_job    job_in, job_out;
    lrc_pkg::t_q_stat q_stat;

    // front: counters, frame tracking, half-block buffer
    lrc_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_first_in_packet (i_first_in_packet),
        .i_azimuth         (i_azimuth),
        .i_distance        (i_distance),
        .i_reflectivity    (i_reflectivity),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_q_stat          (q_stat),
        .o_push            (push),
        .o_job             (job_in)
    );

    // decouple the bursty front from the point unit
    lrc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_stat  (q_stat)
    );

    // back: trig, products, output word
    lrc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_stat        (q_stat),
        .i_job           (job_out),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_x_mm          (o_x_mm),
        .o_y_mm          (o_y_mm),
        .o_z_mm          (o_z_mm),
        .o_intensity     (o_intensity),
        .o_laser_channel (o_laser_channel),
        .o_new_frame     (o_new_frame),
        .o_last          (o_last)
    );

endmodule

>>> design/lrc_checker.sv
// Port-level checks for the converter top level, attached by bind.
// Depends only on the top level's ports.
module lrc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic        o_cfg_ready,
    input logic [17:0] o_x_mm,
    input logic [17:0] o_z_mm,
    input logic [3:0]  o_laser_channel,
    input logic        o_new_frame,
    input logic        o_last
);

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_x_mm) && $stable(o_last))
        else $error("output word changed under stall");

    // drop the output word on reset
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    // a replayed word opens a frame only on laser zero
    a_replay_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_frame && !o_last |-> o_laser_channel == 4'd0)
        else $error("replay frame start not on laser zero");

    // x and z coordinates never fall below -131070
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $signed(o_x_mm) >= -18'sd131070 && $signed(o_z_mm) >= -18'sd131070)
        else $error("coordinate out of range");

    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

endmodule

bind lidar_return_to_cartesian_top lrc_checker u_lrc_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_cfg_ready     (o_cfg_ready),
    .o_x_mm          (o_x_mm),
    .o_z_mm          (o_z_mm),
    .o_laser_channel (o_laser_channel),
    .o_new_frame     (o_new_frame),
    .o_last          (o_last)
);
